@@ design/tvs_pkg.sv @@
package tvs_pkg;

   // Field and datapath widths.
   localparam int OP_W        = 3;
   localparam int DIST_W      = 24;
   localparam int ANGLE_W     = 17;
   localparam int HEADING_W   = 16;
   localparam int OUT_COORD_W = 32;
   localparam int TRIG_W      = 32;
   localparam int Z_W         = 25;
   localparam int PROD_W      = 56;
   localparam int DELTA_W     = 27;
   localparam int FRAC_SHIFT  = 30;

   // Command codes.
   typedef enum logic [OP_W-1:0] {
      OP_FORWARD  = 3'd0,
      OP_BACK     = 3'd1,
      OP_TURN     = 3'd2,
      OP_PEN_UP   = 3'd3,
      OP_PEN_DOWN = 3'd4,
      OP_RESET    = 3'd5
   } op_type;

   // Quadrant codes of the heading.
   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   // Angles in 1/128 degree.
   localparam logic [HEADING_W-1:0] QUARTER_TURN       = 16'd11520;
   localparam logic [HEADING_W-1:0] HALF_TURN          = 16'd23040;
   localparam logic [HEADING_W-1:0] THREE_QUARTER_TURN = 16'd34560;
   localparam logic [HEADING_W-1:0] FULL_TURN          = 16'd46080;
   localparam logic signed [HEADING_W+1:0] FULL_TURN_S = 18'sd46080;

   // CORDIC start vector length, 0.60725 in Q1.30.
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

   // One classified command as it leaves the front end.
   typedef struct packed {
      logic                     move;
      logic                     negate;
      logic                     clear;
      logic                     pen;
      logic [HEADING_W-1:0]     heading;
      logic signed [DIST_W-1:0] distance;
   } cmd_type;

   // One queue entry: the command and the cosine and sine of its heading (Q1.30).
   typedef struct packed {
      cmd_type                  cmd;
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } item_type;

   // Queue status seen by the back end and the checks.
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   // One result item.
   typedef struct packed {
      logic                          draw;
      logic                          clear;
      logic signed [OUT_COORD_W-1:0] from_x;
      logic signed [OUT_COORD_W-1:0] from_y;
      logic signed [OUT_COORD_W-1:0] to_x;
      logic signed [OUT_COORD_W-1:0] to_y;
      logic [HEADING_W-1:0]          heading;
      logic                          pen;
   } rsp_type;

   // Arctangent of 2^-i in 2^-16 degree.
   function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
      case (idx)
         0:       return 25'sd2949120;
         1:       return 25'sd1740967;
         2:       return 25'sd919879;
         3:       return 25'sd466945;
         4:       return 25'sd234379;
         5:       return 25'sd117304;
         6:       return 25'sd58666;
         7:       return 25'sd29335;
         8:       return 25'sd14668;
         9:       return 25'sd7334;
         10:      return 25'sd3667;
         11:      return 25'sd1833;
         12:      return 25'sd917;
         13:      return 25'sd458;
         14:      return 25'sd229;
         15:      return 25'sd115;
         16:      return 25'sd57;
         17:      return 25'sd29;
         18:      return 25'sd14;
         19:      return 25'sd7;
         20:      return 25'sd4;
         21:      return 25'sd2;
         22:      return 25'sd1;
         default: return '0;
      endcase
   endfunction

endpackage

@@ design/tvs_front.sv @@
module tvs_front import tvs_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [OP_W-1:0]           req_op,
   input  logic signed [DIST_W-1:0]  req_distance,
   input  logic signed [ANGLE_W-1:0] req_angle,
   input  logic                      credit_return,
   output logic                      cmd_valid,
   output cmd_type                   cmd
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [HEADING_W-1:0] heading_ff, heading_in;
   logic                 pen_ff, pen_in;
   logic [CW-1:0]        credit_ff, credit_in;
   logic                 valid_ff;
   cmd_type              cmd_ff, cmd_in;
   logic                 accept;
   logic signed [HEADING_W+1:0] turn_sum, wrap_once, wrap_twice;

   // Items accepted but not yet taken by the back end never exceed the queue size.
   assign req_tready = (credit_ff < CW'(DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign credit_in  = credit_ff + CW'(accept) - CW'(credit_return);

   // Heading plus turn amount, wrapped twice into one turn.
   always_comb begin
      turn_sum = $signed({2'b00, heading_ff}) + (HEADING_W+2)'(req_angle);
      wrap_once = turn_sum;
      if (turn_sum >= FULL_TURN_S) begin
         wrap_once = turn_sum - FULL_TURN_S;
      end else if (turn_sum < 0) begin
         wrap_once = turn_sum + FULL_TURN_S;
      end
      wrap_twice = wrap_once;
      if (wrap_once >= FULL_TURN_S) begin
         wrap_twice = wrap_once - FULL_TURN_S;
      end else if (wrap_once < 0) begin
         wrap_twice = wrap_once + FULL_TURN_S;
      end
   end

   // Classify the command and update heading and pen.
   always_comb begin
      heading_in = heading_ff;
      pen_in     = pen_ff;
      cmd_in     = '0;
      case (op_type'(req_op))
         OP_FORWARD, OP_BACK: begin
            cmd_in.move   = 1'b1;
            cmd_in.negate = (op_type'(req_op) == OP_BACK);
         end
         OP_TURN: begin
            heading_in = HEADING_W'(wrap_twice);
         end
         OP_PEN_UP: begin
            pen_in = 1'b0;
         end
         OP_PEN_DOWN: begin
            pen_in = 1'b1;
         end
         OP_RESET: begin
            heading_in   = '0;
            pen_in       = 1'b1;
            cmd_in.clear = 1'b1;
         end
         default: begin
         end
      endcase
      cmd_in.pen      = pen_in;
      cmd_in.heading  = heading_in;
      cmd_in.distance = req_distance;
      if (!accept) begin
         heading_in = heading_ff;
         pen_in     = pen_ff;
      end
   end

   // Pose and credit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         pen_ff     <= 1'b1;
         credit_ff  <= '0;
         valid_ff   <= 1'b0;
      end else begin
         heading_ff <= heading_in;
         pen_ff     <= pen_in;
         credit_ff  <= credit_in;
         valid_ff   <= accept;
      end
   end

   // Command register toward the CORDIC pipeline.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

@@ design/tvs_cordic.sv @@
module tvs_cordic import tvs_pkg::*; #(
   parameter int STAGES = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cmd_type  in_cmd,
   output logic     out_valid,
   output item_type out_item
);

   logic signed [TRIG_W-1:0] x_ff [0:STAGES];
   logic signed [TRIG_W-1:0] y_ff [0:STAGES];
   logic signed [Z_W-1:0]    z_ff [0:STAGES];
   quad_type                 q_ff [0:STAGES];
   cmd_type                  cmd_ff [0:STAGES];
   logic [STAGES:0]          vld_ff;

   logic signed [TRIG_W-1:0] x_in [0:STAGES-1];
   logic signed [TRIG_W-1:0] y_in [0:STAGES-1];
   logic signed [Z_W-1:0]    z_in [0:STAGES-1];

   quad_type                 quad_in;
   logic [HEADING_W-1:0]     rest_in;
   logic signed [TRIG_W-1:0] cos_in, sin_in;
   logic                     out_valid_ff;
   item_type                 out_item_ff;

   // Split the heading into quadrant and remainder.
   always_comb begin
      quad_in = QUAD_0;
      rest_in = in_cmd.heading;
      if (in_cmd.heading >= THREE_QUARTER_TURN) begin
         quad_in = QUAD_3;
         rest_in = in_cmd.heading - THREE_QUARTER_TURN;
      end else if (in_cmd.heading >= HALF_TURN) begin
         quad_in = QUAD_2;
         rest_in = in_cmd.heading - HALF_TURN;
      end else if (in_cmd.heading >= QUARTER_TURN) begin
         quad_in = QUAD_1;
         rest_in = in_cmd.heading - QUARTER_TURN;
      end
   end

   // One micro-rotation per stage, direction from the sign of the residual angle.
   always_comb begin
      for (int i = 0; i < STAGES; i++) begin
         if (!z_ff[i][Z_W-1]) begin
            x_in[i] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i] = z_ff[i] - atan_entry(i);
         end else begin
            x_in[i] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i] = z_ff[i] + atan_entry(i);
         end
      end
   end

   // Apply the quadrant exactly by swapping and negating.
   always_comb begin
      case (q_ff[STAGES])
         QUAD_0: begin
            cos_in = x_ff[STAGES];
            sin_in = y_ff[STAGES];
         end
         QUAD_1: begin
            cos_in = -y_ff[STAGES];
            sin_in = x_ff[STAGES];
         end
         QUAD_2: begin
            cos_in = -x_ff[STAGES];
            sin_in = -y_ff[STAGES];
         end
         default: begin
            cos_in = y_ff[STAGES];
            sin_in = -x_ff[STAGES];
         end
      endcase
   end

   // Datapath registers of the rotation pipeline.
   always_ff @(posedge clock) begin
      x_ff[0]   <= CORDIC_GAIN;
      y_ff[0]   <= '0;
      z_ff[0]   <= $signed({rest_in, 9'b0});
      q_ff[0]   <= quad_in;
      cmd_ff[0] <= in_cmd;
      for (int i = 0; i < STAGES; i++) begin
         x_ff[i+1]   <= x_in[i];
         y_ff[i+1]   <= y_in[i];
         z_ff[i+1]   <= z_in[i];
         q_ff[i+1]   <= q_ff[i];
         cmd_ff[i+1] <= cmd_ff[i];
      end
      out_item_ff.cmd     <= cmd_ff[STAGES];
      out_item_ff.cos_val <= cos_in;
      out_item_ff.sin_val <= sin_in;
   end

   // Valid bits follow the data; the pipeline never stalls.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[STAGES-1:0], in_valid};
         out_valid_ff <= vld_ff[STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

@@ design/tvs_fifo.sv @@
module tvs_fifo import tvs_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output queue_status_type status,
   output item_type         pop_item
);

   localparam int AW = $clog2(DEPTH);

   item_type    mem_ff [0:DEPTH-1];
   item_type    head_ff;
   logic        head_valid_ff, head_valid_in;
   logic [AW:0] wr_ptr_ff, wr_ptr_in;
   logic [AW:0] rd_ptr_ff, rd_ptr_in;
   logic        mem_not_empty;
   logic        load;

   // The head register refills from storage when it is empty or being popped.
   assign mem_not_empty = (wr_ptr_ff != rd_ptr_ff);
   assign load          = mem_not_empty && (!head_valid_ff || pop);
   assign head_valid_in = load || (head_valid_ff && !pop);

   assign wr_ptr_in = wr_ptr_ff + (AW+1)'(push);
   assign rd_ptr_in = rd_ptr_ff + (AW+1)'(load);

   // Storage write and registered read into the head.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_item;
      end
      if (load) begin
         head_ff <= mem_ff[rd_ptr_ff[AW-1:0]];
      end
   end

   // Pointers with a wrap bit to tell full from empty, and the head valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         head_valid_ff <= head_valid_in;
      end
   end

   assign status.not_empty = head_valid_ff;
   assign status.full      = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                             (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   assign pop_item         = head_ff;

endmodule

@@ design/tvs_back.sv @@
module tvs_back import tvs_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   localparam int SUM_W = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 1;
   localparam logic signed [SUM_W-1:0] POS_MAX =
      $signed({{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
   localparam logic signed [PROD_W-1:0] ROUND_HALF =
      $signed({{(PROD_W-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}});

   // Multiply stage.
   logic                     m_valid_ff;
   cmd_type                  m_cmd_ff;
   logic signed [PROD_W-1:0] m_prod_x_ff, m_prod_y_ff;
   // Round stage.
   logic                     r_valid_ff;
   cmd_type                  r_cmd_ff;
   logic signed [DELTA_W-1:0] r_dx_ff, r_dy_ff, dx_in, dy_in;
   logic signed [PROD_W-1:0] round_x, round_y;
   // Accumulate and output stage.
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;
   logic signed [COORD_BITS-1:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   logic a_adv, r_en, m_en;

   // Saturate a wide sum to the coordinate range.
   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [SUM_W-1:0] v
   );
      if (v > POS_MAX) begin
         return COORD_BITS'(POS_MAX);
      end else if (v < POS_MIN) begin
         return COORD_BITS'(POS_MIN);
      end
      return COORD_BITS'(v);
   endfunction

   // Stage enables: each stage loads when it is empty or its successor moves.
   assign a_adv = !rsp_valid_ff || rsp_ready;
   assign r_en  = !r_valid_ff || a_adv;
   assign m_en  = !m_valid_ff || r_en;
   assign q_pop = q_status.not_empty && m_en;

   // Round the product to Q.8, flip for back moves, zero for other commands.
   always_comb begin
      round_x = (m_prod_x_ff + ROUND_HALF) >>> FRAC_SHIFT;
      round_y = (m_prod_y_ff + ROUND_HALF) >>> FRAC_SHIFT;
      dx_in   = DELTA_W'(round_x);
      dy_in   = DELTA_W'(round_y);
      if (m_cmd_ff.negate) begin
         dx_in = -dx_in;
         dy_in = -dy_in;
      end
      if (!m_cmd_ff.move) begin
         dx_in = '0;
         dy_in = '0;
      end
   end

   // New position: saturated sum, or the origin on a clear.
   always_comb begin
      sum_x = SUM_W'(pos_x_ff) + SUM_W'(r_dx_ff);
      sum_y = SUM_W'(pos_y_ff) + SUM_W'(r_dy_ff);
      if (r_cmd_ff.clear) begin
         pos_x_in = '0;
         pos_y_in = '0;
      end else begin
         pos_x_in = sat_coord(sum_x);
         pos_y_in = sat_coord(sum_y);
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (m_en) begin
         m_cmd_ff    <= q_item.cmd;
         m_prod_x_ff <= PROD_W'(q_item.cmd.distance) * PROD_W'(q_item.cos_val);
         m_prod_y_ff <= PROD_W'(q_item.cmd.distance) * PROD_W'(q_item.sin_val);
      end
      if (r_en) begin
         r_cmd_ff <= m_cmd_ff;
         r_dx_ff  <= dx_in;
         r_dy_ff  <= dy_in;
      end
      if (a_adv) begin
         rsp_ff.draw    <= r_cmd_ff.move && r_cmd_ff.pen;
         rsp_ff.clear   <= r_cmd_ff.clear;
         rsp_ff.from_x  <= OUT_COORD_W'(pos_x_ff);
         rsp_ff.from_y  <= OUT_COORD_W'(pos_y_ff);
         rsp_ff.to_x    <= OUT_COORD_W'(pos_x_in);
         rsp_ff.to_y    <= OUT_COORD_W'(pos_y_in);
         rsp_ff.heading <= r_cmd_ff.heading;
         rsp_ff.pen     <= r_cmd_ff.pen;
      end
   end

   // Valid bits and the position accumulator.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
      end else begin
         if (m_en) begin
            m_valid_ff <= q_pop;
         end
         if (r_en) begin
            r_valid_ff <= m_valid_ff;
         end
         if (a_adv) begin
            rsp_valid_ff <= r_valid_ff;
            if (r_valid_ff) begin
               pos_x_ff <= pos_x_in;
               pos_y_ff <= pos_y_in;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/turtle_vector_stepper_unit.sv @@
// Throughput: one item per cycle while rsp_tready is high and queue credits remain; the
// CORDIC rotation is fully pipelined and the position accumulator closes its loop in a single add-and-saturate stage.
// A queue sized to the pipeline depth decouples the trig front end from the output.
// Reset is synchronous and active high: pose at the origin, heading 0, pen down,
// pipeline, queue and output emptied.
module turtle_vector_stepper_unit import tvs_pkg::*; #(
   parameter int COORD_BITS    = 32,
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // distance[23:0], angle[40:24], zero fill[47:41]
   input  logic [47:0]  req_tdata,
   // op[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // from_x[31:0], from_y[63:32], to_x[95:64], to_y[127:96],
   // heading_out[143:128], pen_state[144], zero fill[151:145]
   output logic [151:0] rsp_tdata,
   // draw_line[0], clear_screen[1]
   output logic [1:0]   rsp_tuser
);

   localparam int PIPE_LAT    = CORDIC_STAGES + 3;
   localparam int QUEUE_DEPTH = 1 << $clog2(PIPE_LAT + 3);

   logic signed [DIST_W-1:0]  req_distance;
   logic signed [ANGLE_W-1:0] req_angle;
   logic                      front_valid;
   cmd_type                   front_cmd;
   logic                      trig_valid;
   item_type                  trig_item;
   queue_status_type          q_status;
   item_type                  q_item;
   logic                      q_pop;
   rsp_type                   rsp_data;

   assign req_distance = req_tdata[23:0];
   assign req_angle    = req_tdata[40:24];

   // Accept, classify and track heading and pen.
   tvs_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_op        (req_tuser),
      .req_distance  (req_distance),
      .req_angle     (req_angle),
      .credit_return (q_pop),
      .cmd_valid     (front_valid),
      .cmd           (front_cmd)
   );

   // Cosine and sine of the heading.
   tvs_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_cmd    (front_cmd),
      .out_valid (trig_valid),
      .out_item  (trig_item)
   );

   // Queue between the trig front end and the back end.
   tvs_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (trig_valid),
      .push_item (trig_item),
      .pop       (q_pop),
      .status    (q_status),
      .pop_item  (q_item)
   );

   // Scale, accumulate position and hold the result.
   tvs_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tdata = {7'b0, rsp_data.pen, rsp_data.heading, rsp_data.to_y, rsp_data.to_x,
                       rsp_data.from_y, rsp_data.from_x};
   assign rsp_tuser = {rsp_data.clear, rsp_data.draw};

   // The credit scheme must keep the queue from overflowing.
   assert property (@(posedge clock) disable iff (reset)
      trig_valid |-> !q_status.full)
      else $error("queue push while full");

   // A result never both draws and clears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data.draw && rsp_data.clear))
      else $error("draw and clear in one result");

   // A clear leaves the pose at the origin, heading 0 and pen down.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data.clear) |->
         (rsp_data.to_x == '0 && rsp_data.to_y == '0 && rsp_data.heading == '0 &&
          rsp_data.pen))
      else $error("clear result with nonzero pose");

   // Heading stays inside one turn.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data.heading < FULL_TURN))
      else $error("heading out of range");

endmodule

@@ sim/turtle_vector_stepper_unit_test.sv @@
`timescale 1ns / 100ps

module turtle_vector_stepper_unit_test;
   import tvs_pkg::*;

   localparam int COORD_BITS    = 32;
   localparam int CORDIC_STAGES = 16;
   localparam int LATENCY       = CORDIC_STAGES + 7;
   localparam int QUIET_LIMIT   = 4000;

   // Command codes the block leaves unused.
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   // Angles in 1/128 degree, as signed integers.
   localparam int FULL_CIRCLE  = 46080;
   localparam int RIGHT_ANGLE  = 11520;
   localparam int EIGHTH_TURN  = 5760;

   // Field extremes.
   localparam logic signed [DIST_W-1:0]  DIST_MAX  = 24'sh7FFFFF;
   localparam logic signed [DIST_W-1:0]  DIST_MIN  = 24'sh800000;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 17'sh0FFFF;
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 17'sh10000;

   // One expected result item.
   typedef struct {
      bit                draw;
      bit                clear;
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic [15:0]        heading;
      bit                 pen;
   } pose_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // distance[23:0], angle[40:24], zero fill[47:41]
   logic [47:0]  req_tdata = '0;
   // op[2:0]
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // from_x[31:0], from_y[63:32], to_x[95:64], to_y[127:96],
   // heading_out[143:128], pen_state[144], zero fill[151:145]
   logic [151:0] rsp_tdata;
   // draw_line[0], clear_screen[1]
   logic [1:0]   rsp_tuser;

   // Predicted pose of the turtle.
   longint pose_x;
   longint pose_y;
   int     pose_heading;
   bit     pose_pen;

   pose_result_type expected_poses[$];
   int           error_count   = 0;
   int           results_seen  = 0;
   int           quiet_cycles  = 0;
   int           stall_left    = 0;
   bit           idle_on       = 1'b1;

   turtle_vector_stepper_unit #(
      .COORD_BITS   (COORD_BITS),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #1 clock = ~clock;

   // Arctangent of 2^-i in 2^-16 degree.
   function automatic longint arctan_step(int i);
      case (i)
         0:       return 2949120;
         1:       return 1740967;
         2:       return 919879;
         3:       return 466945;
         4:       return 234379;
         5:       return 117304;
         6:       return 58666;
         7:       return 29335;
         8:       return 14668;
         9:       return 7334;
         10:      return 3667;
         11:      return 1833;
         12:      return 917;
         13:      return 458;
         14:      return 229;
         15:      return 115;
         16:      return 57;
         17:      return 29;
         18:      return 14;
         19:      return 7;
         20:      return 4;
         21:      return 2;
         22:      return 1;
         default: return 0;
      endcase
   endfunction

   // Cosine and sine of a heading in Q1.30: rotate the remainder within the
   // quadrant, then place the quadrant by swapping and negating.
   function automatic void heading_trig(input int h, output longint c, output longint s);
      int     quad;
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      quad = (h / RIGHT_ANGLE) & 3;
      z    = longint'(h % RIGHT_ANGLE) * 512;
      x    = longint'(CORDIC_GAIN);
      y    = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_step(i);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_step(i);
         end
      end
      case (quad)
         0:       begin c = x;  s = y;  end
         1:       begin c = -y; s = x;  end
         2:       begin c = -x; s = -y; end
         default: begin c = y;  s = -x; end
      endcase
   endfunction

   // Distance times a Q1.30 factor, rounded half up to Q.8.
   function automatic longint scale_by_trig(longint d, longint t);
      return (d * t + (longint'(1) <<< 29)) >>> 30;
   endfunction

   function automatic longint clamp_coord(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic int wrap_once(int h);
      if (h >= FULL_CIRCLE) return h - FULL_CIRCLE;
      if (h < 0) return h + FULL_CIRCLE;
      return h;
   endfunction

   // Applies one command to the predicted pose and returns its result item.
   function automatic pose_result_type step_turtle(logic [OP_W-1:0] op,
                                                   logic signed [DIST_W-1:0] move_len,
                                                   logic signed [ANGLE_W-1:0] ang);
      pose_result_type r;
      longint       c;
      longint       s;
      longint       dx;
      longint       dy;
      r.draw   = 1'b0;
      r.clear  = 1'b0;
      r.from_x = pose_x[31:0];
      r.from_y = pose_y[31:0];
      case (op)
         OP_FORWARD, OP_BACK: begin
            heading_trig(pose_heading, c, s);
            dx = scale_by_trig(longint'(move_len), c);
            dy = scale_by_trig(longint'(move_len), s);
            if (op == OP_BACK) begin
               dx = -dx;
               dy = -dy;
            end
            pose_x = clamp_coord(pose_x + dx);
            pose_y = clamp_coord(pose_y + dy);
            r.draw = pose_pen;
         end
         OP_TURN: begin
            pose_heading = wrap_once(wrap_once(pose_heading + int'(ang)));
         end
         OP_PEN_UP: begin
            pose_pen = 1'b0;
         end
         OP_PEN_DOWN: begin
            pose_pen = 1'b1;
         end
         OP_RESET: begin
            pose_x       = 0;
            pose_y       = 0;
            pose_heading = 0;
            pose_pen     = 1'b1;
            r.clear      = 1'b1;
         end
         default: begin
         end
      endcase
      r.to_x    = pose_x[31:0];
      r.to_y    = pose_y[31:0];
      r.heading = pose_heading[15:0];
      r.pen     = pose_pen;
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_delay();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offers one item, waits for it to be taken and records its expected result.
   task automatic send_command(input logic [OP_W-1:0] op,
                               input logic signed [DIST_W-1:0] move_len,
                               input logic signed [ANGLE_W-1:0] ang);
      int gap;
      gap = pick_delay();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {7'b0, ang, move_len};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_poses.push_back(step_turtle(op, move_len, ang));
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      error_count++;
      if (error_count <= 10)
         $display("result %0d: %s expected %h got %h", results_seen, what, want, got);
   endtask

   // Every operation, field extremes, quadrant edges, wraps beyond one turn,
   // pen-up moves and the unused codes.
   task automatic test_directed();
      idle_on = 1'b1;
      send_command(OP_RESET, '0, '0);
      send_command(OP_FORWARD, DIST_MAX, '0);
      send_command(OP_BACK, DIST_MIN, '0);
      send_command(OP_TURN, '0, ANGLE_W'(RIGHT_ANGLE));
      send_command(OP_FORWARD, DIST_W'(256), '0);
      send_command(OP_TURN, '0, ANGLE_W'(RIGHT_ANGLE));
      send_command(OP_FORWARD, DIST_W'(256), '0);
      send_command(OP_TURN, '0, ANGLE_W'(RIGHT_ANGLE));
      send_command(OP_BACK, DIST_W'(256), '0);
      send_command(OP_TURN, '0, ANGLE_W'(46079));
      send_command(OP_TURN, '0, ANGLE_W'(-46079));
      send_command(OP_TURN, '0, ANGLE_MAX);
      send_command(OP_TURN, '0, ANGLE_MIN);
      send_command(OP_PEN_UP, '0, '0);
      send_command(OP_FORWARD, DIST_W'(1000), '0);
      send_command(OP_BACK, DIST_W'(-777), '0);
      send_command(OP_PEN_DOWN, '0, '0);
      send_command(OP_SPARE_6, DIST_MAX, ANGLE_MAX);
      send_command(OP_SPARE_7, DIST_MIN, ANGLE_MIN);
      send_command(OP_FORWARD, '0, '0);
      send_command(OP_FORWARD, DIST_W'(-1), '0);
      send_command(OP_RESET, DIST_MAX, ANGLE_MAX);
   endtask

   // Long runs of full-length moves drive x to its upper limit and y to its
   // lower limit, then keep moving while pinned.
   task automatic test_saturation();
      idle_on = 1'b0;
      send_command(OP_RESET, '0, '0);
      repeat (270) send_command(OP_FORWARD, DIST_MAX, '0);
      send_command(OP_TURN, '0, ANGLE_W'(RIGHT_ANGLE));
      repeat (270) send_command(OP_BACK, DIST_MAX, '0);
      send_command(OP_TURN, '0, ANGLE_W'(EIGHTH_TURN));
      send_command(OP_PEN_UP, '0, '0);
      send_command(OP_BACK, DIST_MIN, '0);
      send_command(OP_FORWARD, DIST_MAX, '0);
      send_command(OP_RESET, '0, '0);
      idle_on = 1'b1;
   endtask

   // Random command streams: mostly moves and turns, with pen changes,
   // occasional resets and a few unused codes.
   task automatic test_random(input int count);
      logic [OP_W-1:0]           op;
      logic signed [DIST_W-1:0]  move_len;
      logic signed [ANGLE_W-1:0] ang;
      int                        r;
      for (int n = 0; n < count; n++) begin
         // Alternate stretches with and without idling.
         if (n % 120 == 0) idle_on = (n % 240 == 0);
         r = $urandom_range(0, 9);
         if (r < 5) move_len = DIST_W'($urandom_range(0, 8191) - 4096);
         else if (r < 8) move_len = DIST_W'($urandom);
         else begin
            case ($urandom_range(0, 3))
               0:       move_len = DIST_MAX;
               1:       move_len = DIST_MIN;
               2:       move_len = '0;
               default: move_len = '1;
            endcase
         end
         r = $urandom_range(0, 9);
         if (r < 6) ang = ANGLE_W'($urandom_range(0, 92158) - 46079);
         else if (r < 8) ang = ANGLE_W'((int'($urandom_range(0, 16)) - 8) * EIGHTH_TURN);
         else ang = ANGLE_W'($urandom);
         r = $urandom_range(0, 99);
         if (r < 40) op = OP_FORWARD;
         else if (r < 60) op = OP_BACK;
         else if (r < 80) op = OP_TURN;
         else if (r < 86) op = OP_PEN_UP;
         else if (r < 92) op = OP_PEN_DOWN;
         else if (r < 95) op = OP_RESET;
         else if (r < 98) op = OP_SPARE_6;
         else op = OP_SPARE_7;
         send_command(op, move_len, ang);
      end
      idle_on = 1'b1;
   endtask

   // Result back-pressure, in runs of ready and stall cycles.
   always @(negedge clock) begin
      int d;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         d = pick_delay();
         rsp_tready <= (d == 0);
         stall_left <= (d > 0) ? d - 1 : 0;
      end
   end

   // Compares each result item with the oldest expected pose.
   always @(posedge clock) begin
      pose_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_poses.size() == 0) begin
            flag_mismatch("result with nothing pending", '0, '0);
         end else begin
            want = expected_poses.pop_front();
            if (rsp_tuser[0] !== want.draw)
               flag_mismatch("draw_line", 32'(want.draw), 32'(rsp_tuser[0]));
            if (rsp_tuser[1] !== want.clear)
               flag_mismatch("clear_screen", 32'(want.clear), 32'(rsp_tuser[1]));
            if (rsp_tdata[31:0] !== want.from_x)
               flag_mismatch("from_x", want.from_x, rsp_tdata[31:0]);
            if (rsp_tdata[63:32] !== want.from_y)
               flag_mismatch("from_y", want.from_y, rsp_tdata[63:32]);
            if (rsp_tdata[95:64] !== want.to_x)
               flag_mismatch("to_x", want.to_x, rsp_tdata[95:64]);
            if (rsp_tdata[127:96] !== want.to_y)
               flag_mismatch("to_y", want.to_y, rsp_tdata[127:96]);
            if (rsp_tdata[143:128] !== want.heading)
               flag_mismatch("heading_out", 32'(want.heading), 32'(rsp_tdata[143:128]));
            if (rsp_tdata[144] !== want.pen)
               flag_mismatch("pen_state", 32'(want.pen), 32'(rsp_tdata[144]));
         end
      end
   end

   // Ends the run if no item moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      pose_x       = 0;
      pose_y       = 0;
      pose_heading = 0;
      pose_pen     = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_saturation();
      test_random(480);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
